@@ hw/rtl/jwst_pkg.sv @@
// ============================================================================
// jwst_pkg
// Shared types, codes and defaults of the journal write-set tracker.
// ============================================================================
package jwst_pkg;

    localparam int LOG_SLOTS_DEF  = 32;
    localparam int DISKS_DEF      = 2;
    localparam int BLOCK_BITS_DEF = 24;

    localparam int BLOCK_W  = 24;
    localparam int DEVICE_W = 8;
    localparam int STATUS_W = 4;
    localparam int SLOT_W   = 5;
    localparam int OPEN_W   = 6;
    localparam int RESERVE_W = 6;
    localparam int NEED_W   = 13;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_RESERVE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_BASE = 1'd1;

    localparam logic [RESERVE_W-1:0] RESERVE_RST   = 6'd10;
    localparam logic [DEVICE_W-1:0]  ROOT_BASE_RST = 8'd1;

    localparam logic [STATUS_W-1:0] ST_GRANTED = 4'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NEW     = 4'd2;
    localparam logic [STATUS_W-1:0] ST_ABSORB  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_ENDED   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_COMMIT  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 4'd6;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 4'd7;
    localparam logic [STATUS_W-1:0] ST_FULL    = 4'd8;
    localparam logic [STATUS_W-1:0] ST_BAD     = 4'd9;

    typedef struct packed {
        logic [1:0]          command;
        logic [DEVICE_W-1:0] device_number;
        logic [BLOCK_W-1:0]  block_number;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic                commit_disk;
        logic [BLOCK_W-1:0]  commit_block;
        logic                last_result;
    } t_result;

    typedef struct packed {
        logic                load;
        logic                need_load;
        logic                emit;
        logic [STATUS_W-1:0] status;
        logic                open_inc;
        logic                open_dec;
        logic                idx_clr;
        logic                disk_clr;
        logic                disk_next;
        logic                rd_issue;
        logic                append;
        logic                counts_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic dev_ok;
        logic open_zero;
        logic open_one;
        logic begin_blocked;
        logic log_full;
        logic counts_zero;
        logic walk_end;
        logic pos_valid;
        logic more_disk;
        logic pend;
        logic match;
    } t_dp_status;

endpackage

@@ hw/rtl/jwst_ram.sv @@
// ============================================================================
// jwst_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module jwst_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/jwst_ctrl.sv @@
// ============================================================================
// jwst_ctrl
// Sequencer for begin, end/commit and block-write words.
// ============================================================================
module jwst_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_command,
    input  jwst_pkg::t_dp_status i_status,
    output jwst_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_BEG_MUL  = 8'b0000_0010,
        S_BEG_CHK  = 8'b0000_0100,
        S_END      = 8'b0000_1000,
        S_CM_WALK  = 8'b0001_0000,
        S_CM_DRAIN = 8'b0010_0000,
        S_WR_CHK   = 8'b0100_0000,
        S_WR_WALK  = 8'b1000_0000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    jwst_pkg::t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    case (i_command)
                        jwst_pkg::CMD_BEGIN: n_state = S_BEG_MUL;
                        jwst_pkg::CMD_END:   n_state = S_END;
                        jwst_pkg::CMD_WRITE: n_state = S_WR_CHK;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_BEG_MUL: begin
                cmd.need_load = 1'b1;
                n_state       = S_BEG_CHK;
            end
            S_BEG_CHK: begin
                cmd.emit = 1'b1;
                if (i_status.begin_blocked) begin
                    cmd.status = jwst_pkg::ST_BLOCKED;
                end else begin
                    cmd.status   = jwst_pkg::ST_GRANTED;
                    cmd.open_inc = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_END: begin
                n_state = S_IDLE;
                if (i_status.open_zero) begin
                    cmd.emit   = 1'b1;
                    cmd.status = jwst_pkg::ST_BAD;
                end else if (!i_status.open_one) begin
                    cmd.emit     = 1'b1;
                    cmd.status   = jwst_pkg::ST_ENDED;
                    cmd.open_dec = 1'b1;
                end else if (i_status.counts_zero) begin
                    cmd.emit     = 1'b1;
                    cmd.status   = jwst_pkg::ST_EMPTY;
                    cmd.open_dec = 1'b1;
                end else begin
                    cmd.open_dec = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    cmd.disk_clr = 1'b1;
                    n_state      = S_CM_WALK;
                end
            end
            S_CM_WALK: begin
                if (i_status.pend) begin
                    cmd.emit   = 1'b1;
                    cmd.status = jwst_pkg::ST_COMMIT;
                end
                if (i_status.pos_valid) begin
                    cmd.rd_issue = 1'b1;
                end else if (i_status.more_disk) begin
                    cmd.disk_next = 1'b1;
                end else begin
                    cmd.counts_clr = 1'b1;
                    n_state        = S_CM_DRAIN;
                end
            end
            S_CM_DRAIN: begin
                if (i_status.pend) begin
                    cmd.emit   = 1'b1;
                    cmd.status = jwst_pkg::ST_COMMIT;
                end
                n_state = S_IDLE;
            end
            S_WR_CHK: begin
                n_state  = S_IDLE;
                cmd.emit = 1'b1;
                if (!i_status.dev_ok) begin
                    cmd.status = jwst_pkg::ST_BAD;
                end else if (i_status.open_zero) begin
                    cmd.status = jwst_pkg::ST_OUTSIDE;
                end else if (i_status.log_full) begin
                    cmd.status = jwst_pkg::ST_FULL;
                end else begin
                    cmd.emit    = 1'b0;
                    cmd.idx_clr = 1'b1;
                    n_state     = S_WR_WALK;
                end
            end
            S_WR_WALK: begin
                if (i_status.match) begin
                    cmd.emit   = 1'b1;
                    cmd.status = jwst_pkg::ST_ABSORB;
                    n_state    = S_IDLE;
                end else if (i_status.walk_end && !i_status.pend) begin
                    cmd.emit   = 1'b1;
                    cmd.status = jwst_pkg::ST_NEW;
                    cmd.append = 1'b1;
                    n_state    = S_IDLE;
                end else if (!i_status.walk_end) begin
                    cmd.rd_issue = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

@@ hw/rtl/jwst_dp.sv @@
// ============================================================================
// jwst_dp
// Datapath: configuration, open count, per-disk log counts, log RAM walk
// and the result register.
// ============================================================================
module jwst_dp #(
    parameter int LOG_SLOTS  = jwst_pkg::LOG_SLOTS_DEF,
    parameter int DISKS      = jwst_pkg::DISKS_DEF,
    parameter int BLOCK_BITS = jwst_pkg::BLOCK_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  jwst_pkg::t_item                     i_item,
    input  logic                                i_cfg_we,
    input  logic [jwst_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [jwst_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  jwst_pkg::t_dp_cmd                   i_cmd,
    output jwst_pkg::t_dp_status                o_status,
    output logic                                o_valid,
    output jwst_pkg::t_result                   o_result
);

    localparam int CW      = $clog2(LOG_SLOTS + 1);
    localparam int SW      = $clog2(LOG_SLOTS);
    localparam int STORE_W = (BLOCK_BITS < jwst_pkg::BLOCK_W) ? BLOCK_BITS : jwst_pkg::BLOCK_W;
    localparam int DEPTH   = DISKS * LOG_SLOTS;
    localparam int AW      = $clog2(DEPTH);

    logic [jwst_pkg::RESERVE_W-1:0] r_reserve;
    logic [jwst_pkg::DEVICE_W-1:0]  r_base;
    logic [jwst_pkg::OPEN_W-1:0]    r_open;
    logic [CW-1:0]                  r_count [DISKS];
    logic [jwst_pkg::NEED_W-1:0]    r_need;
    logic [STORE_W-1:0]             r_block;
    logic                           r_disk;
    logic                           r_dev_ok;
    logic [CW-1:0]                  r_idx;
    logic                           r_pend;
    logic [SW-1:0]                  r_pend_idx;
    logic                           r_pend_disk;
    logic                           r_pend_last;
    logic                           r_out_valid;
    jwst_pkg::t_result              r_out;

    logic [jwst_pkg::DEVICE_W:0]    dev_diff;
    logic                           dev_ok;
    logic [CW-1:0]                  cnt_sel;
    logic [6:0]                     open_p1;
    logic [jwst_pkg::NEED_W-1:0]    n_need;
    logic                           blocked;
    logic                           counts_zero;
    logic                           more_disk;
    logic                           pend_last;
    logic [STORE_W-1:0]             rd_data;
    logic [AW-1:0]                  rd_addr;
    logic [AW-1:0]                  wr_addr;
    jwst_pkg::t_result              n_out;

    assign dev_diff = {1'b0, i_item.device_number} - {1'b0, r_base};
    assign dev_ok   = !dev_diff[jwst_pkg::DEVICE_W]
                      && (dev_diff[jwst_pkg::DEVICE_W-1:0] < jwst_pkg::DEVICE_W'(DISKS));

    assign cnt_sel   = (DISKS > 1 && r_disk) ? r_count[DISKS-1] : r_count[0];
    assign more_disk = (DISKS > 1) && !r_disk;
    assign open_p1   = {1'b0, r_open} + 7'd1;
    assign n_need    = jwst_pkg::NEED_W'(open_p1) * jwst_pkg::NEED_W'(r_reserve);

    always_comb begin
        blocked     = (r_open == '1);
        counts_zero = 1'b1;
        for (int d = 0; d < DISKS; d++) begin
            if ((14'(r_count[d]) + 14'(r_need)) > 14'(LOG_SLOTS)) begin
                blocked = 1'b1;
            end
            if (r_count[d] != '0) begin
                counts_zero = 1'b0;
            end
        end
    end

    assign pend_last = (({1'b0, r_idx} + 1'b1) >= {1'b0, cnt_sel})
                       && !(more_disk && (r_count[DISKS-1] != '0));

    assign rd_addr = AW'(r_idx[SW-1:0]) + (r_disk ? AW'(LOG_SLOTS) : AW'(0));
    assign wr_addr = AW'(cnt_sel[SW-1:0]) + (r_disk ? AW'(LOG_SLOTS) : AW'(0));

    jwst_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_log_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.append),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_block),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        o_status.dev_ok        = r_dev_ok;
        o_status.open_zero     = (r_open == '0);
        o_status.open_one      = (r_open == jwst_pkg::OPEN_W'(1));
        o_status.begin_blocked = blocked;
        o_status.log_full      = (cnt_sel >= CW'(LOG_SLOTS));
        o_status.counts_zero   = counts_zero;
        o_status.walk_end      = (r_idx >= cnt_sel);
        o_status.pos_valid     = (r_idx < cnt_sel);
        o_status.more_disk     = more_disk;
        o_status.pend          = r_pend;
        o_status.match         = r_pend && (rd_data == r_block);
    end

    always_comb begin
        n_out             = '0;
        n_out.status      = i_cmd.status;
        n_out.last_result = 1'b1;
        case (i_cmd.status)
            jwst_pkg::ST_NEW: begin
                n_out.slot_index   = jwst_pkg::SLOT_W'(cnt_sel);
                n_out.commit_disk  = r_disk;
                n_out.commit_block = jwst_pkg::BLOCK_W'(r_block);
            end
            jwst_pkg::ST_ABSORB: begin
                n_out.slot_index   = jwst_pkg::SLOT_W'(r_pend_idx);
                n_out.commit_disk  = r_disk;
                n_out.commit_block = jwst_pkg::BLOCK_W'(r_block);
            end
            jwst_pkg::ST_COMMIT: begin
                n_out.slot_index   = jwst_pkg::SLOT_W'(r_pend_idx);
                n_out.commit_disk  = r_pend_disk;
                n_out.commit_block = jwst_pkg::BLOCK_W'(rd_data);
                n_out.last_result  = r_pend_last;
            end
            jwst_pkg::ST_OUTSIDE, jwst_pkg::ST_FULL: begin
                n_out.commit_disk = r_disk;
            end
            default: begin
                n_out.slot_index = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserve   <= jwst_pkg::RESERVE_RST;
            r_base      <= jwst_pkg::ROOT_BASE_RST;
            r_open      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int d = 0; d < DISKS; d++) begin
                r_count[d] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    jwst_pkg::CFG_RESERVE:   r_reserve <= i_cfg_data[jwst_pkg::RESERVE_W-1:0];
                    jwst_pkg::CFG_ROOT_BASE: r_base    <= i_cfg_data;
                    default:                 r_base    <= r_base;
                endcase
            end
            if (i_cmd.open_inc) begin
                r_open <= r_open + 1'b1;
            end else if (i_cmd.open_dec) begin
                r_open <= r_open - 1'b1;
            end
            for (int d = 0; d < DISKS; d++) begin
                if (i_cmd.counts_clr) begin
                    r_count[d] <= '0;
                end else if (i_cmd.append && (r_disk == 1'(d))) begin
                    r_count[d] <= r_count[d] + 1'b1;
                end
            end
            r_pend      <= i_cmd.rd_issue;
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_block  <= i_item.block_number[STORE_W-1:0];
            r_disk   <= dev_diff[0];
            r_dev_ok <= dev_ok;
        end else if (i_cmd.disk_clr) begin
            r_disk <= 1'b0;
        end else if (i_cmd.disk_next) begin
            r_disk <= 1'b1;
        end
        if (i_cmd.need_load) begin
            r_need <= n_need;
        end
        if (i_cmd.idx_clr || i_cmd.disk_next) begin
            r_idx <= '0;
        end else if (i_cmd.rd_issue) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.rd_issue) begin
            r_pend_idx  <= r_idx[SW-1:0];
            r_pend_disk <= r_disk;
            r_pend_last <= pend_last;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

@@ hw/rtl/journal_write_set_tracker_core.sv @@
// ============================================================================
// journal_write_set_tracker_core
// Write-set tracker of a redo journal over one or two disks with group commit.
// ============================================================================
// A write walks the log of its disk; a commit walks the log of every disk in turn.
// One word at a time: the next word is taken only once the tracker is idle again;
// the serial log RAM walk sets write and commit time.
// Results are strobed for one cycle each; the receiver cannot stall.
// Synchronous active-low reset clears counts and returns config to its defaults; log RAM is not cleared.
module journal_write_set_tracker_core #(
    parameter int LOG_SLOTS  = jwst_pkg::LOG_SLOTS_DEF,
    parameter int DISKS      = jwst_pkg::DISKS_DEF,
    parameter int BLOCK_BITS = jwst_pkg::BLOCK_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  jwst_pkg::t_item                  i_item,
    input  logic                             i_cfg_we,
    input  logic [jwst_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [jwst_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_result_valid,
    output jwst_pkg::t_result                o_result
);

    jwst_pkg::t_dp_cmd    dp_cmd;
    jwst_pkg::t_dp_status dp_status;

    jwst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_item.command),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd),
        .o_busy    (busy)
    );

    jwst_dp #(
        .LOG_SLOTS  (LOG_SLOTS),
        .DISKS      (DISKS),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_valid     (o_result_valid),
        .o_result    (o_result)
    );

endmodule

@@ hw/rtl/jwst_checker.sv @@
// ============================================================================
// jwst_checker
// Port-level checks of the journal write-set tracker, bound to the top level.
// ============================================================================
module jwst_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input jwst_pkg::t_item   i_item,
    input logic              o_result_valid,
    input jwst_pkg::t_result o_result
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result strobe after reset");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_result.status != jwst_pkg::ST_COMMIT)
        |-> o_result.last_result)
        else $error("single-result word without last flag");

    a_plain_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && ((o_result.status == jwst_pkg::ST_GRANTED)
        || (o_result.status == jwst_pkg::ST_BLOCKED)
        || (o_result.status == jwst_pkg::ST_ENDED)
        || (o_result.status == jwst_pkg::ST_EMPTY)
        || (o_result.status == jwst_pkg::ST_BAD))
        |-> (o_result.slot_index == '0) && (o_result.commit_block == '0)
            && !o_result.commit_disk)
        else $error("slot fields set on a status that carries none");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && ((i_item.command == jwst_pkg::CMD_BEGIN)
        || (i_item.command == jwst_pkg::CMD_END)
        || (i_item.command == jwst_pkg::CMD_WRITE)) |=> busy)
        else $error("accepted word did not raise busy");

endmodule

bind journal_write_set_tracker_core jwst_checker u_jwst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_item         (i_item),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

@@ bench/journal_write_set_tracker_core_test.sv @@
// ============================================================================
// journal_write_set_tracker_core_test
// Self-checking bench for the journal write-set tracker core. A table of
// directed words comes first, then random journal traffic under several
// register settings. The bench keeps its own copy of the tracker state, and
// every strobed result is checked field by field against the expected one.
// ============================================================================
module journal_write_set_tracker_core_test;
    import jwst_pkg::*;

    localparam int DISKS         = DISKS_DEF;
    localparam int SLOTS         = LOG_SLOTS_DEF;
    localparam int OPEN_LIMIT    = 63;
    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 55;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 3000;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int PHASE_RESERVE [PHASES] = '{10, 0, 1, 32, 63, 4};
    localparam int PHASE_BASE    [PHASES] = '{1, 0, 254, 255, 128, 7};

    typedef struct packed {
        t_item   word;
        logic    typed;
        t_result want;
    } t_row;

    localparam t_result R_NONE    = t_result'(0);
    localparam t_result R_GRANTED = {ST_GRANTED, 5'd0, 1'b0, 24'h000000, 1'b1};
    localparam t_result R_BLOCKED = {ST_BLOCKED, 5'd0, 1'b0, 24'h000000, 1'b1};
    localparam t_result R_ENDED   = {ST_ENDED,   5'd0, 1'b0, 24'h000000, 1'b1};
    localparam t_result R_EMPTY   = {ST_EMPTY,   5'd0, 1'b0, 24'h000000, 1'b1};
    localparam t_result R_BAD     = {ST_BAD,     5'd0, 1'b0, 24'h000000, 1'b1};

    localparam t_row DIRECTED [24] = '{
        {CMD_END,    8'h00, 24'h000000, 1'b1, R_BAD},
        {CMD_WRITE,  8'h01, 24'h000005, 1'b1, ST_OUTSIDE, 5'd0, 1'b0, 24'h0, 1'b1},
        {CMD_WRITE,  8'h00, 24'h000000, 1'b1, R_BAD},
        {CMD_WRITE,  8'hFF, 24'hFFFFFF, 1'b1, R_BAD},
        {CMD_WRITE,  8'h03, 24'h000000, 1'b1, R_BAD},
        {CMD_UNUSED, 8'hFF, 24'hFFFFFF, 1'b0, R_NONE},
        {CMD_BEGIN,  8'hFF, 24'hFFFFFF, 1'b1, R_GRANTED},
        {CMD_BEGIN,  8'h00, 24'h000000, 1'b1, R_GRANTED},
        {CMD_BEGIN,  8'h00, 24'h000000, 1'b1, R_GRANTED},
        {CMD_BEGIN,  8'h00, 24'h000000, 1'b1, R_BLOCKED},
        {CMD_WRITE,  8'h01, 24'h000000, 1'b1, ST_NEW, 5'd0, 1'b0, 24'h000000, 1'b1},
        {CMD_WRITE,  8'h02, 24'hFFFFFF, 1'b1, ST_NEW, 5'd0, 1'b1, 24'hFFFFFF, 1'b1},
        {CMD_WRITE,  8'h01, 24'h000000, 1'b1, ST_ABSORB, 5'd0, 1'b0, 24'h000000, 1'b1},
        {CMD_WRITE,  8'h01, 24'h123456, 1'b0, R_NONE},
        {CMD_WRITE,  8'h02, 24'hFFFFFF, 1'b1, ST_ABSORB, 5'd0, 1'b1, 24'hFFFFFF, 1'b1},
        {CMD_WRITE,  8'h01, 24'hAAAAAA, 1'b0, R_NONE},
        {CMD_WRITE,  8'h02, 24'h555555, 1'b0, R_NONE},
        {CMD_END,    8'h00, 24'h000000, 1'b1, R_ENDED},
        {CMD_END,    8'h00, 24'h000000, 1'b1, R_ENDED},
        {CMD_END,    8'h00, 24'h000000, 1'b0, R_NONE},
        {CMD_END,    8'h00, 24'h000000, 1'b1, R_BAD},
        {CMD_BEGIN,  8'h00, 24'h000000, 1'b1, R_GRANTED},
        {CMD_END,    8'h00, 24'h000000, 1'b1, R_EMPTY},
        {CMD_UNUSED, 8'h00, 24'h000000, 1'b0, R_NONE}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_item                  i_item;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   o_result_valid;
    t_result                o_result;

    int                     reserve_cfg;
    int                     root_base_cfg;
    int                     open_ops;
    int                     log_count [DISKS];
    logic [BLOCK_W-1:0]     log_block [DISKS][SLOTS];
    t_result                predicted [$];
    t_result                pending_results [$];
    int                     errors = 0;
    int                     sent = 0;
    int                     idle_cycles = 0;
    bit                     calm = 1'b0;

    always #5 i_clk = ~i_clk;

    journal_write_set_tracker_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    function automatic t_result status_word(logic [STATUS_W-1:0] st, int slot, int disk,
                                            logic [BLOCK_W-1:0] blk, logic last);
        t_result r;
        r.status       = st;
        r.slot_index   = SLOT_W'(slot);
        r.commit_disk  = disk[0];
        r.commit_block = blk;
        r.last_result  = last;
        return r;
    endfunction

    function automatic void journal_predict(t_item w);
        int  need;
        int  dev;
        int  disk;
        int  n;
        bit  blocked;
        bit  hit;
        predicted.delete();
        case (w.command)
            CMD_BEGIN: begin
                blocked = (open_ops >= OPEN_LIMIT);
                need = (open_ops + 1) * reserve_cfg;
                for (int d = 0; d < DISKS; d++)
                    if (log_count[d] + need > SLOTS) blocked = 1'b1;
                if (!blocked) open_ops++;
                predicted.push_back(status_word(blocked ? ST_BLOCKED : ST_GRANTED,
                                                0, 0, '0, 1'b1));
            end
            CMD_END: begin
                if (open_ops == 0) begin
                    predicted.push_back(status_word(ST_BAD, 0, 0, '0, 1'b1));
                end else begin
                    open_ops--;
                    if (open_ops != 0) begin
                        predicted.push_back(status_word(ST_ENDED, 0, 0, '0, 1'b1));
                    end else begin
                        for (int d = 0; d < DISKS; d++) begin
                            for (int i = 0; i < log_count[d]; i++)
                                predicted.push_back(status_word(ST_COMMIT, i, d,
                                                                log_block[d][i], 1'b0));
                            log_count[d] = 0;
                        end
                        if (predicted.size() == 0)
                            predicted.push_back(status_word(ST_EMPTY, 0, 0, '0, 1'b1));
                        else
                            predicted[predicted.size()-1].last_result = 1'b1;
                    end
                end
            end
            CMD_WRITE: begin
                dev = int'(w.device_number);
                if (dev < root_base_cfg || dev - root_base_cfg >= DISKS) begin
                    predicted.push_back(status_word(ST_BAD, 0, 0, '0, 1'b1));
                end else begin
                    disk = dev - root_base_cfg;
                    n = log_count[disk];
                    if (open_ops == 0) begin
                        predicted.push_back(status_word(ST_OUTSIDE, 0, disk, '0, 1'b1));
                    end else if (n >= SLOTS) begin
                        predicted.push_back(status_word(ST_FULL, 0, disk, '0, 1'b1));
                    end else begin
                        hit = 1'b0;
                        for (int i = 0; i < n && !hit; i++) begin
                            if (log_block[disk][i] == w.block_number) begin
                                hit = 1'b1;
                                predicted.push_back(status_word(ST_ABSORB, i, disk,
                                                                w.block_number, 1'b1));
                            end
                        end
                        if (!hit) begin
                            log_block[disk][n] = w.block_number;
                            log_count[disk] = n + 1;
                            predicted.push_back(status_word(ST_NEW, n, disk,
                                                            w.block_number, 1'b1));
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [DEVICE_W-1:0] pick_device();
        if ($urandom_range(0, 99) < 85)
            return DEVICE_W'(root_base_cfg + $urandom_range(0, DISKS-1));
        return DEVICE_W'($urandom);
    endfunction

    function automatic logic [BLOCK_W-1:0] pick_block();
        if ($urandom_range(0, 1) == 0)
            return BLOCK_W'($urandom_range(0, 7));
        return BLOCK_W'($urandom);
    endfunction

    task automatic push_word(t_item w, logic typed, t_result want);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        journal_predict(w);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (predicted[k]) pending_results.push_back(predicted[k]);
        if (w.command != CMD_UNUSED) sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_RESERVE)
            reserve_cfg = int'(data[RESERVE_W-1:0]);
        else
            root_base_cfg = int'(data);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if ((start && !busy) || o_result_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else if (o_result_valid) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected word: status %0d slot %0d block %h",
                           o_result.status, o_result.slot_index, o_result.commit_block);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_result.status);
                        errors++;
                    end
                    if (o_result.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, o_result.slot_index);
                        errors++;
                    end
                    if (o_result.commit_disk !== want.commit_disk) begin
                        $error("commit_disk: expected %0d, got %0d",
                               want.commit_disk, o_result.commit_disk);
                        errors++;
                    end
                    if (o_result.commit_block !== want.commit_block) begin
                        $error("commit_block: expected %h, got %h",
                               want.commit_block, o_result.commit_block);
                        errors++;
                    end
                    if (o_result.last_result !== want.last_result) begin
                        $error("last_result: expected %0d, got %0d",
                               want.last_result, o_result.last_result);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        int                 kind;
        int                 disk;
        int                 phase_start;
        bit                 nest_done;
        logic [BLOCK_W-1:0] first;
        logic [BLOCK_W-1:0] blk;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_item        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        reserve_cfg   = int'(RESERVE_RST);
        root_base_cfg = int'(ROOT_BASE_RST);
        open_ops      = 0;
        nest_done     = 1'b0;
        foreach (log_count[d]) log_count[d] = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r])
            push_word(DIRECTED[r].word, DIRECTED[r].typed, DIRECTED[r].want);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            calm = (p == PHASES - 1);
            write_reg(CFG_RESERVE, {2'($urandom), 6'(PHASE_RESERVE[p])});
            write_reg(CFG_ROOT_BASE, p == PHASES - 1 ? 8'($urandom) : 8'(PHASE_BASE[p]));
            phase_start = sent;
            while (sent - phase_start < PHASE_WORDS) begin
                kind = $urandom_range(0, 99);
                if (reserve_cfg == 0 && !nest_done) begin
                    // walk the open count to its ceiling and back down
                    nest_done = 1'b1;
                    repeat (OPEN_LIMIT + 1)
                        push_word({CMD_BEGIN, 8'($urandom), 24'($urandom)}, 1'b0, R_NONE);
                    repeat (OPEN_LIMIT + 1)
                        push_word({CMD_END, 8'($urandom), 24'($urandom)}, 1'b0, R_NONE);
                end else if (kind < 5) begin
                    // fill one disk's log past the top, then rewrite a logged block
                    disk  = $urandom_range(0, DISKS - 1);
                    first = {8'd0, 16'($urandom)};
                    push_word({CMD_BEGIN, 8'($urandom), 24'($urandom)}, 1'b0, R_NONE);
                    for (int j = 0; j < SLOTS + 2; j++) begin
                        blk = (j == 0 || j == SLOTS + 1) ? first : {8'(j), 16'($urandom)};
                        push_word({CMD_WRITE, 8'(root_base_cfg + disk), blk}, 1'b0, R_NONE);
                    end
                    push_word({CMD_END, 8'($urandom), 24'($urandom)}, 1'b0, R_NONE);
                end else if (kind < 75) begin
                    push_word({CMD_BEGIN, 8'($urandom), 24'($urandom)}, 1'b0, R_NONE);
                    repeat ($urandom_range(0, 6))
                        push_word({CMD_WRITE, pick_device(), pick_block()}, 1'b0, R_NONE);
                    if ($urandom_range(0, 2) == 0) begin
                        push_word({CMD_BEGIN, 8'($urandom), 24'($urandom)}, 1'b0, R_NONE);
                        repeat ($urandom_range(1, 3))
                            push_word({CMD_WRITE, pick_device(), pick_block()}, 1'b0, R_NONE);
                        push_word({CMD_END, 8'($urandom), 24'($urandom)}, 1'b0, R_NONE);
                    end
                    push_word({CMD_END, 8'($urandom), 24'($urandom)}, 1'b0, R_NONE);
                end else begin
                    push_word({2'($urandom), 8'($urandom), 24'($urandom)}, 1'b0, R_NONE);
                end
            end
            // close whatever is still open so the phase ends with no open operation
            while (open_ops > 0)
                push_word({CMD_END, 8'($urandom), 24'($urandom)}, 1'b0, R_NONE);
        end

        drain();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
